### hdl/utfpe_pkg.sv
// ----------------------------------------------------------------------------
// utfpe_pkg
// Shared types, constants and helpers of the UTF-8 to percent-escaped text
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package utfpe_pkg;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_PCT    = 8'h25;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A_OFF  = 8'h37;   // 'A' - 10

   localparam int unsigned CODE_W = 21;

   // Position inside one percent escape
   typedef enum logic [1:0] {
      PH_PCT = 2'd0,
      PH_HI  = 2'd1,
      PH_LO  = 2'd2
   } phase_type;

   // One unit of output work handed from the decoder to the emitter
   typedef struct packed {
      logic             is_ascii;
      logic [7:0]       ascii_char;
      logic [1:0]       byte_cnt;     // nonzero code point bytes, 1..3
      logic [2:0][7:0]  code_bytes;   // compacted, index 0 emitted first
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + {4'h0, nib};
      end else begin
         return CHAR_A_OFF + {4'h0, nib};
      end
   endfunction

endpackage

`default_nettype wire

### hdl/utfpe_if.sv
// ----------------------------------------------------------------------------
// utfpe_req_if / utfpe_rsp_if
// Valid/ready channels for input bytes and output characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface utfpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utfpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/utf8_to_percent_escaped_text_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_percent_escaped_text_unit
// UTF-8 byte stream in, 8-bit text with percent escapes out.
//
// req_ch takes one UTF-8 byte per word with an end_of_text flag; rsp_ch
// gives one output character per word, last_of_run marking the final
// character caused by an input byte. ASCII passes through (CR dropped,
// LF turned into CR); a finished multibyte sequence becomes '%' plus two
// hex digits per nonzero code point byte, up to nine characters.
// After a byte is accepted, its first character goes through the job
// register, then the result register.
// Throughput: one character per cycle while rsp_ch is ready, set by the
// single result register; a byte that yields no character gives none, an
// ASCII byte one, a finishing multibyte byte three per nonzero code point byte.
// A new byte is taken while the previous job drains its last character.
// Reset clears the sequence state, the job valid and the result valid.
// When rsp_ch stalls, the result holds, the job register fills and req_ch
// ready drops until the job can move on.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_percent_escaped_text_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   utfpe_req_if.sink   req_ch,
   utfpe_rsp_if.source rsp_ch
);
   import utfpe_pkg::*;

   job_type job;
   logic    job_valid;
   logic    job_take;

   utfpe_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job       (job),
      .job_valid (job_valid),
      .job_take  (job_take)
   );

   utfpe_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_take  (job_take),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

### hdl/utfpe_decode.sv
// ----------------------------------------------------------------------------
// utfpe_decode
// Tracks the UTF-8 sequence state and turns each accepted byte into an
// output job held in a one-entry job register.
// ----------------------------------------------------------------------------
`default_nettype none

module utfpe_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   utfpe_req_if.sink              req_ch,
   output utfpe_pkg::job_type     job,
   output logic                   job_valid,
   input  wire logic              job_take
);
   import utfpe_pkg::*;

   logic [1:0]        remain_ff, remain_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic              discard_ff, discard_in;
   logic              job_valid_ff, job_valid_in;
   job_type           job_ff, job_in;

   logic              accept;
   logic [7:0]        b;
   logic [CODE_W-1:0] acc_next;
   logic [2:0][7:0]   raw_bytes;
   logic [2:0][7:0]   packed_bytes;
   logic [1:0]        nz_cnt;
   logic              new_job;
   job_type           new_job_data;

   assign req_ch.ready = !job_valid_ff || job_take;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.text_byte;
   assign acc_next     = {acc_ff[CODE_W-7:0], b[5:0]};

   // Gather nonzero bytes of the finished code point, high byte first
   assign raw_bytes[2] = {3'b000, acc_next[20:16]};
   assign raw_bytes[1] = acc_next[15:8];
   assign raw_bytes[0] = acc_next[7:0];

   always_comb begin
      packed_bytes = '0;
      nz_cnt       = 2'd0;
      for (int i = 2; i >= 0; i--) begin
         if (raw_bytes[i] != 8'h00) begin
            packed_bytes[nz_cnt] = raw_bytes[i];
            nz_cnt               = nz_cnt + 2'd1;
         end
      end
   end

   always_comb begin
      remain_in    = remain_ff;
      acc_in       = acc_ff;
      discard_in   = discard_ff;
      new_job      = 1'b0;
      new_job_data = '0;

      if (accept) begin
         if (discard_ff) begin
            // drop everything up to end of text
         end else if (remain_ff != 2'd0) begin
            acc_in    = acc_next;
            remain_in = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               acc_in                  = '0;
               new_job                 = (nz_cnt != 2'd0);
               new_job_data.byte_cnt   = nz_cnt;
               new_job_data.code_bytes = packed_bytes;
            end
         end else if (b < ASCII_LIMIT) begin
            if (b != CHAR_CR) begin
               new_job                 = 1'b1;
               new_job_data.is_ascii   = 1'b1;
               new_job_data.ascii_char = (b == CHAR_LF) ? CHAR_CR : b;
            end
         end else if (!b[5]) begin
            acc_in    = {16'h0000, b[4:0]};
            remain_in = 2'd1;
         end else if (!b[4]) begin
            acc_in    = {17'h00000, b[3:0]};
            remain_in = 2'd2;
         end else if (!b[3]) begin
            acc_in    = {18'h00000, b[2:0]};
            remain_in = 2'd3;
         end else begin
            discard_in = 1'b1;
         end

         if (req_ch.end_of_text) begin
            remain_in  = 2'd0;
            acc_in     = '0;
            discard_in = 1'b0;
         end
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff && !job_take;
      job_in       = job_ff;
      if (new_job) begin
         job_valid_in = 1'b1;
         job_in       = new_job_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= 2'd0;
         acc_ff       <= '0;
         discard_ff   <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         acc_ff       <= acc_in;
         discard_ff   <= discard_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job       = job_ff;
   assign job_valid = job_valid_ff;

endmodule

`default_nettype wire

### hdl/utfpe_emit.sv
// ----------------------------------------------------------------------------
// utfpe_emit
// Walks one job character by character into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module utfpe_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire utfpe_pkg::job_type job,
   input  wire logic              job_valid,
   output logic                   job_take,
   utfpe_rsp_if.source            rsp_ch
);
   import utfpe_pkg::*;

   logic [1:0] idx_ff, idx_in;
   phase_type  phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic       load;
   logic [7:0] cur_byte;
   logic       job_last;

   assign load     = job_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign cur_byte = job.code_bytes[idx_ff];
   assign job_last = job.is_ascii ||
                     ((phase_ff == PH_LO) && (idx_ff == job.byte_cnt - 2'd1));
   assign job_take = load && job_last;

   always_comb begin
      case (phase_ff)
         PH_PCT:  char_in = CHAR_PCT;
         PH_HI:   char_in = hex_char(cur_byte[7:4]);
         PH_LO:   char_in = hex_char(cur_byte[3:0]);
         default: char_in = CHAR_PCT;
      endcase
      if (job.is_ascii) begin
         char_in = job.ascii_char;
      end
      last_in = job_last;
   end

   always_comb begin
      idx_in   = idx_ff;
      phase_in = phase_ff;
      if (load) begin
         if (job_last) begin
            idx_in   = 2'd0;
            phase_in = PH_PCT;
         end else begin
            case (phase_ff)
               PH_PCT:  phase_in = PH_HI;
               PH_HI:   phase_in = PH_LO;
               PH_LO: begin
                  phase_in = PH_PCT;
                  idx_in   = idx_ff + 2'd1;
               end
               default: phase_in = PH_PCT;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         phase_ff     <= PH_PCT;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_char    = char_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule

`default_nettype wire
